// File: rtl/core/utrt_pkg.sv
package utrt_pkg;

  // Status codes carried on every result
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RADIX = 2'd1,
    ST_NO_ROOM   = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIVIDE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_FETCH  = 6'b001000,
    S_LOAD   = 6'b010000,
    S_SEND   = 6'b100000
  } state_e;

  // Accepted radix range
  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  // Quotient bits resolved per divider cycle
  localparam int unsigned BITS_PER_STEP = 4;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;

  // Map a digit value to its lower-case ASCII glyph
  function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
    logic [7:0] glyph;
    if (digit < 4'd10) begin
      glyph = CHAR_ZERO + {4'd0, digit};
    end else begin
      glyph = CHAR_LOW_A + {4'd0, digit} - 8'd10;
    end
    return glyph;
  endfunction

endpackage

// File: rtl/core/unsigned_to_radix_text.sv
// A bad radix gives its status result in the cycle after the request is taken.
// Each digit is worked out by the shared 4-bit-per-cycle divider, then the room check runs,
// then the digits are sent through the fetch, load and send states, and the NUL follows.
// One request at a time; the next is taken after the final result leaves.
// Reset (rst_ni low, asynchronous) returns to idle with no result pending; the digit
// store is not cleared.
module unsigned_to_radix_text #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [4:0]            radix_i,
  input  logic [5:0]            buffer_size_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            char_out_o,
  output logic [5:0]            digit_total_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  localparam int unsigned STEP_BITS = utrt_pkg::BITS_PER_STEP;
  localparam int unsigned STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_BITS  = STEPS * STEP_BITS;
  localparam int unsigned STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned ADDR_W    = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W     = $clog2(VALUE_BITS + 1);
  localparam int unsigned CMP_W     = (CNT_W > 6) ? CNT_W : 6;

  utrt_pkg::state_e state_q, state_d;

  logic [PAD_BITS-1:0] div_q, div_d;
  logic [3:0]          rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [4:0]          radix_q, radix_d;
  logic [5:0]          size_q, size_d;
  logic [ADDR_W-1:0]   rd_addr_q, rd_addr_d;
  logic [3:0]          rd_data_q;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          char_q, char_d;
  logic [5:0]          total_q, total_d;
  utrt_pkg::status_e   status_q, status_d;
  logic                last_q, last_d;

  logic                     in_fire;
  logic                     out_fire;
  logic                     step_last;
  logic                     digit_wr;
  logic [STEP_BITS-1:0]     qbits;
  logic [3:0]               rem_step;
  logic [PAD_BITS-1:0]      div_step;

  // Digit store, least significant digit at entry zero
  logic [3:0] store_q [VALUE_BITS];

  assign in_stall_o    = (state_q != utrt_pkg::S_IDLE);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign out_fire      = out_valid_q && !out_stall_i;
  assign char_out_o    = char_q;
  assign digit_total_o = total_q;
  assign status_o      = status_q;
  assign last_o        = last_q;
  assign step_last     = (step_q == STEP_W'(STEPS - 1));

  // Shared divider: resolve four quotient bits of the top of the dividend
  always_comb begin
    logic [3:0] r;
    logic [4:0] t;
    r     = rem_q;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, div_q[PAD_BITS-1-i]};
      if (t >= radix_q) begin
        t                          = t - radix_q;
        qbits[STEP_BITS-1-i]       = 1'b1;
      end
      r = t[3:0];
    end
    rem_step = r;
    div_step = {div_q[PAD_BITS-STEP_BITS-1:0], qbits};
  end

  assign digit_wr = (state_q == utrt_pkg::S_DIVIDE) && step_last;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    radix_d     = radix_q;
    size_d      = size_q;
    rd_addr_d   = rd_addr_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    total_d     = total_q;
    status_d    = status_q;
    last_d      = last_q;

    unique case (state_q)
      utrt_pkg::S_IDLE: begin
        if (in_fire) begin
          radix_d = radix_i;
          size_d  = buffer_size_i;
          div_d   = PAD_BITS'(value_i);
          rem_d   = '0;
          step_d  = '0;
          cnt_d   = '0;
          if (radix_i < utrt_pkg::RADIX_MIN || radix_i > utrt_pkg::RADIX_MAX) begin
            // Reject the radix with a single status result
            out_valid_d = 1'b1;
            char_d      = utrt_pkg::CHAR_NUL;
            total_d     = '0;
            status_d    = utrt_pkg::ST_BAD_RADIX;
            last_d      = 1'b1;
            state_d     = utrt_pkg::S_SEND;
          end else begin
            state_d = utrt_pkg::S_DIVIDE;
          end
        end
      end

      utrt_pkg::S_DIVIDE: begin
        div_d  = div_step;
        rem_d  = rem_step;
        step_d = step_q + STEP_W'(1);
        if (step_last) begin
          // Digit done: count it, then stop once the quotient is zero
          cnt_d  = cnt_q + CNT_W'(1);
          rem_d  = '0;
          step_d = '0;
          if (div_step == '0) begin
            state_d = utrt_pkg::S_CHECK;
          end
        end
      end

      utrt_pkg::S_CHECK: begin
        if (CMP_W'(cnt_q) >= CMP_W'(size_q)) begin
          out_valid_d = 1'b1;
          char_d      = utrt_pkg::CHAR_NUL;
          total_d     = '0;
          status_d    = utrt_pkg::ST_NO_ROOM;
          last_d      = 1'b1;
          cnt_d       = '0;
          state_d     = utrt_pkg::S_SEND;
        end else begin
          rd_addr_d = ADDR_W'(cnt_q - CNT_W'(1));
          total_d   = 6'(cnt_q);
          status_d  = utrt_pkg::ST_OK;
          state_d   = utrt_pkg::S_FETCH;
        end
      end

      utrt_pkg::S_FETCH: begin
        state_d = utrt_pkg::S_LOAD;
      end

      utrt_pkg::S_LOAD: begin
        out_valid_d = 1'b1;
        char_d      = utrt_pkg::digit_glyph(rd_data_q);
        last_d      = 1'b0;
        state_d     = utrt_pkg::S_SEND;
      end

      utrt_pkg::S_SEND: begin
        if (out_fire) begin
          if (last_q) begin
            out_valid_d = 1'b0;
            state_d     = utrt_pkg::S_IDLE;
          end else if (rd_addr_q == '0) begin
            // Least significant digit gone: append the terminator
            char_d = utrt_pkg::CHAR_NUL;
            last_d = 1'b1;
          end else begin
            out_valid_d = 1'b0;
            rd_addr_d   = rd_addr_q - ADDR_W'(1);
            state_d     = utrt_pkg::S_FETCH;
          end
        end
      end

      default: begin
        state_d     = utrt_pkg::S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utrt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    rem_q     <= rem_d;
    radix_q   <= radix_d;
    size_q    <= size_d;
    rd_addr_q <= rd_addr_d;
    char_q    <= char_d;
    total_q   <= total_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  // Digit store: write the finished remainder, registered read
  always_ff @(posedge clk_i) begin
    if (digit_wr) begin
      store_q[cnt_q[ADDR_W-1:0]] <= rem_step;
    end
    rd_data_q <= store_q[rd_addr_q];
  end

endmodule
